>>> rtl/core/gnn_pkg.sv
// ============================================================================
// gnn_pkg: shared types, constants and functions for gnn_layer_forward
// Opcode codes, fixed-point limits and the tanh lookup with interpolation.
// ============================================================================
package gnn_pkg;

    localparam int LANES          = 8;
    localparam int FEATURE_DIM_DEF = 8;
    localparam int ACC_W          = 40;
    localparam int DATA_W         = 16;
    localparam int SCORE_W        = 24;
    localparam int HID_W          = 16;
    localparam int IDX_W          = 3;

    typedef enum logic [1:0] {
        OP_WR_WEIGHT = 2'd0,
        OP_WR_PROJ   = 2'd1,
        OP_FEATURE   = 2'd2,
        OP_CLOSE     = 2'd3
    } opcode_t;

    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [HID_W-1:0]   hid_t;
    typedef logic signed [DATA_W-1:0]  data_t;
    typedef logic signed [SCORE_W-1:0] score_t;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    function automatic logic [14:0] tanh_tab(input logic [4:0] i);
        logic [14:0] v;
        case (i)
            5'd0:  v = 15'd0;     5'd1:  v = 15'd4013;  5'd2:  v = 15'd7571;
            5'd3:  v = 15'd10406; 5'd4:  v = 15'd12478; 5'd5:  v = 15'd13898;
            5'd6:  v = 15'd14830; 5'd7:  v = 15'd15423; 5'd8:  v = 15'd15795;
            5'd9:  v = 15'd16024; 5'd10: v = 15'd16165; 5'd11: v = 15'd16251;
            5'd12: v = 15'd16303; 5'd13: v = 15'd16335; 5'd14: v = 15'd16354;
            5'd15: v = 15'd16366; 5'd16: v = 15'd16373; 5'd17: v = 15'd16377;
            5'd18: v = 15'd16380; 5'd19: v = 15'd16382; 5'd20: v = 15'd16383;
            5'd21: v = 15'd16383; 5'd22: v = 15'd16383; 5'd23: v = 15'd16384;
            5'd24: v = 15'd16384;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

    // tanh of a Q.20 value, result Q1.14
    function automatic hid_t tanh_q(input acc_t x);
        logic [ACC_W-1:0] m;
        logic [4:0]       idx;
        logic [17:0]      frac;
        logic [14:0]      y0;
        logic [14:0]      y1;
        logic [12:0]      d;
        logic [31:0]      prod;
        logic [14:0]      y;
        m    = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
        idx  = m[22:18];
        frac = m[17:0];
        y0   = tanh_tab(idx);
        y1   = tanh_tab(5'(idx + 5'd1));
        d    = 13'(y1 - y0);
        prod = 32'(d) * 32'(frac) + 32'h20000;
        if (m >= (ACC_W'(6) << 20)) y = 15'd16384;
        else y = 15'(y0 + 15'(prod[31:18]));
        return x[ACC_W-1] ? -hid_t'({1'b0, y}) : hid_t'({1'b0, y});
    endfunction

endpackage

>>> rtl/core/gnn_ram.sv
// ============================================================================
// gnn_ram: generic single-port-write, single-read RAM
// Registered read.
// ============================================================================
module gnn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

>>> rtl/core/gnn_layer_forward.sv
// ============================================================================
// gnn_layer_forward: one graph message-passing layer, one node at a time
// Weight/projection writes, neighbor feature accumulation and node close.
// ============================================================================
// Usage:
//   Slave stream carries one command per transaction (weight write, projection
//   write, neighbor feature element, node close); s_tuser holds the opcode.
//   Only a close gives a result transaction on the master stream: probability,
//   score and eight hidden values.
//   Throughput: one command per cycle, back to back, unless a stalled master holds the pipe.
//   Weights sit in one RAM per hidden row, addressed by column; a feature reads
//   all rows of its column at acceptance and the products are registered before
//   they are summed into the accumulators. A write always lands before any later read.
//   A close runs on through tanh, products, sum/round and sigmoid; m_tvalid
//   rises from the output register once the close has passed all of these stages.
//   Projection writes pass the pw2, pw3 and pw4 registers before they reach proj_reg,
//   and are applied once any close ahead of them has read the vector.
//   Every stage advances only when the output register is free or being taken,
//   so a stalled master stops the whole pipe and s_tready drops; nothing is lost.
//   Reset: unwritten weights read as zero through 64 valid bits, so no clearing
//   pass is needed; accumulators and projection are flip-flops cleared at once.
// ============================================================================
module gnn_layer_forward
    import gnn_pkg::*;
#(
    parameter int FEATURE_WIDTH_DIM = FEATURE_DIM_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // opcode[1:0]
    input  logic [23:0]  s_tdata,   // row_index[2:0], col_index[5:3], data_value[21:6], zero[23:22]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata    // probability[15:0], score[39:16], hidden_0..7[167:40]
);
    localparam int ADIM = (FEATURE_WIDTH_DIM < LANES) ? FEATURE_WIDTH_DIM : LANES;

    // pipeline advances when output slot is free or being taken
    logic adv;
    logic out_v_reg;
    assign adv      = !out_v_reg || m_tready;
    assign s_tready = adv;

    logic    acc_in;
    opcode_t in_op;
    logic [IDX_W-1:0] in_row, in_col;
    data_t   in_val;
    assign acc_in = s_tvalid && s_tready;
    assign in_op  = opcode_t'(s_tuser);
    assign in_row = s_tdata[2:0];
    assign in_col = s_tdata[5:3];
    assign in_val = s_tdata[21:6];

    // stage 1 registers
    logic             s1_v_reg;
    opcode_t          s1_op_reg;
    logic [IDX_W-1:0] s1_col_reg;
    data_t            s1_val_reg;
    logic [LANES-1:0] s1_wv_reg;

    logic in_wr_ok;
    assign in_wr_ok = acc_in && in_op == OP_WR_WEIGHT &&
                      32'(in_row) < ADIM && 32'(in_col) < ADIM;

    // weight memory: one RAM per row j, addressed by column k
    logic [LANES-1:0]  wv_reg [LANES];   // entry [j][k] written since reset
    logic [LANES-1:0]  row_wr;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_w [LANES];

    // no input is taken during a stall, so re-reading the held column is safe
    assign rd_addr = adv ? in_col : s1_col_reg;

    for (genvar g = 0; g < LANES; g++) begin : g_wram
        assign row_wr[g] = in_wr_ok && 32'(in_row) == g;
        gnn_ram #(.WIDTH(DATA_W), .DEPTH(LANES)) u_wram (
            .aclk    (aclk),
            .wr_en   (row_wr[g]),
            .wr_addr (in_col),
            .wr_data (in_val),
            .rd_addr (rd_addr),
            .rd_data (rd_w[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < LANES; j++) wv_reg[j] <= '0;
        end else if (in_wr_ok) begin
            wv_reg[in_row][in_col] <= 1'b1;
        end
    end

    // stage 1: capture command while memory read is in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) s1_v_reg <= 1'b0;
        else if (adv) s1_v_reg <= acc_in;
        if (adv) begin
            s1_op_reg  <= in_op;
            s1_col_reg <= in_col;
            s1_val_reg <= in_val;
            for (int j = 0; j < LANES; j++) s1_wv_reg[j] <= wv_reg[j][in_col];
        end
    end

    // projection vector; writes ride along the pipe so a close ahead sees old data
    logic             pw2_v_reg, pw3_v_reg, pw4_v_reg;
    logic [IDX_W-1:0] pw2_col_reg, pw3_col_reg, pw4_col_reg;
    data_t            pw2_val_reg, pw3_val_reg, pw4_val_reg;
    data_t            proj_reg [LANES];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw2_v_reg <= 1'b0;
            pw3_v_reg <= 1'b0;
            pw4_v_reg <= 1'b0;
            for (int i = 0; i < LANES; i++) proj_reg[i] <= '0;
        end else if (adv) begin
            pw2_v_reg <= s1_v_reg && s1_op_reg == OP_WR_PROJ && 32'(s1_col_reg) < ADIM;
            pw3_v_reg <= pw2_v_reg;
            pw4_v_reg <= pw3_v_reg;
            if (pw4_v_reg) proj_reg[pw4_col_reg] <= pw4_val_reg;
        end
        if (adv) begin
            pw2_col_reg <= s1_col_reg;
            pw2_val_reg <= s1_val_reg;
            pw3_col_reg <= pw2_col_reg;
            pw3_val_reg <= pw2_val_reg;
            pw4_col_reg <= pw3_col_reg;
            pw4_val_reg <= pw3_val_reg;
        end
    end

    // stage 2: multiply feature by each weight of the column
    logic signed [31:0] prod_reg [LANES];
    logic               s2_feat_reg, s2_v_reg, s2_close_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (adv) begin
            s2_v_reg <= s1_v_reg;
        end
        if (adv) begin
            s2_feat_reg  <= s1_v_reg && s1_op_reg == OP_FEATURE && 32'(s1_col_reg) < ADIM;
            s2_close_reg <= s1_v_reg && s1_op_reg == OP_CLOSE;
            for (int j = 0; j < LANES; j++)
                prod_reg[j] <= 32'(s1_val_reg) *
                               (s1_wv_reg[j] ? 32'($signed(rd_w[j])) : 32'sd0);
        end
    end

    function automatic acc_t sat_add(input acc_t a, input logic signed [31:0] p);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(p);
        if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

    // stage 3: accumulate with saturation; close snapshots and clears
    acc_t acc_reg [LANES];
    acc_t snap_reg [LANES];
    logic s3_close_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < LANES; j++) acc_reg[j] <= '0;
            s3_close_reg <= 1'b0;
        end else if (adv) begin
            s3_close_reg <= s2_v_reg && s2_close_reg;
            for (int j = 0; j < LANES; j++) begin
                if (s2_v_reg && s2_close_reg) acc_reg[j] <= '0;
                else if (s2_v_reg && s2_feat_reg && j < ADIM)
                    acc_reg[j] <= sat_add(acc_reg[j], prod_reg[j]);
            end
        end
        if (adv) for (int j = 0; j < LANES; j++) snap_reg[j] <= acc_reg[j];
    end

    // stage 4: tanh of each accumulator
    hid_t hid_reg [LANES];
    logic s4_v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s4_v_reg <= 1'b0;
        else if (adv) s4_v_reg <= s3_close_reg;
        if (adv) for (int j = 0; j < LANES; j++)
            hid_reg[j] <= (j < ADIM) ? tanh_q(snap_reg[j]) : '0;
    end

    // stage 5: products hidden*projection (Q.26)
    logic signed [31:0] hp_reg [LANES];
    hid_t hid5_reg [LANES];
    logic s5_v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s5_v_reg <= 1'b0;
        else if (adv) s5_v_reg <= s4_v_reg;
        if (adv) for (int j = 0; j < LANES; j++) begin
            hp_reg[j]   <= 32'(hid_reg[j]) * 32'(proj_reg[j]);
            hid5_reg[j] <= hid_reg[j];
        end
    end

    // stage 6: sum and round half up
    logic signed [34:0] sum;
    logic signed [34:0] t;
    logic signed [20:0] sc;
    always_comb begin
        sum = '0;
        for (int j = 0; j < LANES; j++) sum = sum + 35'(hp_reg[j]);
        t  = sum + 35'sd8192;
        sc = t[34:14];   // floor(t/16384), fits in 24 bits without saturation
    end
    score_t score_reg;
    hid_t   hid6_reg [LANES];
    logic   s6_v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s6_v_reg <= 1'b0;
        else if (adv) s6_v_reg <= s5_v_reg;
        if (adv) begin
            score_reg <= SCORE_W'(sc);
            for (int j = 0; j < LANES; j++) hid6_reg[j] <= hid5_reg[j];
        end
    end

    // stage 7: sigmoid into output register
    hid_t             th;
    logic signed [17:0] pr;
    logic [15:0]      prob;
    always_comb begin
        th = tanh_q(ACC_W'(score_reg) <<< 7);
        pr = 18'sd32768 + 18'(th) * 18'sd2;
        if (pr > 18'sd65535) prob = 16'hFFFF;
        else if (pr < 0) prob = 16'h0;
        else prob = pr[15:0];
    end

    logic [167:0] out_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (adv) out_v_reg <= s6_v_reg;
        if (adv) begin
            out_reg[15:0]  <= prob;
            out_reg[39:16] <= score_reg;
            for (int j = 0; j < LANES; j++) out_reg[40 + j*HID_W +: HID_W] <= hid6_reg[j];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

endmodule

>>> rtl/core/gnn_checker.sv
// ============================================================================
// gnn_checker: port-level checks for gnn_layer_forward
// Stream stability and result sanity.
// ============================================================================
module gnn_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed under stall");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with output empty");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

    a_hid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[55:40]) <= 16'sd16384 &&
                     $signed(m_tdata[55:40]) >= -16'sd16384)
        else $error("hidden out of range");
endmodule

bind gnn_layer_forward gnn_checker u_gnn_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
